// File: design/fpr_pkg.sv
`default_nettype none

package fpr_pkg;

  // Defaults for the top-level parameters
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed widths of the register and the counters
  localparam int CFG_W   = 5;
  localparam int TOTAL_W = 32;

  // Status that each cell reports back to the top level
  typedef struct packed {
    logic match;   // live entry equal to the looked-up page
    logic oldest;  // this cell holds the oldest resident page
  } cell_stat_t;

endpackage

`default_nettype wire

// File: design/fpr_cell.sv
`default_nettype none

module fpr_cell
  import fpr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  parameter int IDX       = 0,
  localparam int CNT_W    = $clog2(FRAMES + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 shift,
  input  wire logic [PAGE_BITS-1:0] prev_page,
  input  wire logic [PAGE_BITS-1:0] lookup_page,
  input  wire logic [CNT_W-1:0]     count,
  output logic      [PAGE_BITS-1:0] page,
  output logic      [PAGE_BITS-1:0] victim,
  output cell_stat_t                stat
);

  localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(IDX + 1);

  logic live;

  // Age position: cell 0 holds the newest page
  always_ff @(posedge clk) begin
    if (shift) begin
      page <= prev_page;
    end
  end

  assign live        = (POS < count);
  assign stat.match  = live && (page == lookup_page);
  assign stat.oldest = (POS_NEXT == count);
  assign victim      = stat.oldest ? page : '0;

endmodule

`default_nettype wire

// File: design/fifo_page_replacement.sv
`default_nettype none

// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-----------------------------------------
// request   | in        | in_valid / in_stall | page_number
// result    | out       | out_valid/out_stall | hit, evicted_valid, evicted_page,
//           |           |                     | hit_count, fault_count
// config    | in        | cfg_we              | cfg_data (frames_in_use)
//
// One request per cycle while the output side does not stall: every cell compares
// against the request at once, and the result is registered. The output register is the only stage.
// A request is taken whenever the output register is empty or being drained.
// rst (synchronous) empties the store, clears both totals, sets frames_in_use
// to 16. Page storage itself is not reset; residency is tracked by a count.

module fifo_page_replacement
  import fpr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PAGE_BITS-1:0] page_number,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      hit,
  output logic                      evicted_valid,
  output logic      [PAGE_BITS-1:0] evicted_page,
  output logic      [TOTAL_W-1:0]   hit_count,
  output logic      [TOTAL_W-1:0]   fault_count
);

  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CAP_W-1:0]   CAP_MAX   = CAP_W'(FRAMES);
  localparam logic [CAP_W-1:0]   CAP_MIN   = CAP_W'(1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Registers
  logic [CFG_W-1:0]   frames_in_use;
  logic [CNT_W-1:0]   resident_count;
  logic [CNT_W-1:0]   resident_count_next;
  logic [TOTAL_W-1:0] hits_total;
  logic [TOTAL_W-1:0] hits_total_next;
  logic [TOTAL_W-1:0] faults_total;
  logic [TOTAL_W-1:0] faults_total_next;

  // Cell chain
  logic [PAGE_BITS-1:0] cell_page   [FRAMES];
  logic [PAGE_BITS-1:0] cell_victim [FRAMES];
  cell_stat_t           cell_stat   [FRAMES];

  logic                 accept;
  logic                 found;
  logic                 evict;
  logic                 shift;
  logic [CAP_W-1:0]     cfg_ext;
  logic [CAP_W-1:0]     capacity;
  logic [PAGE_BITS-1:0] victim;

  // Output register decouples the two sides
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Effective capacity: zero reads as one, oversize clamps to FRAMES
  assign cfg_ext = CAP_W'(frames_in_use);
  always_comb begin
    if (cfg_ext == '0) begin
      capacity = CAP_MIN;
    end else if (cfg_ext > CAP_MAX) begin
      capacity = CAP_MAX;
    end else begin
      capacity = cfg_ext;
    end
  end

  generate
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      fpr_cell #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX       (g)
      ) u_cell (
        .clk         (clk),
        .shift       (shift),
        .prev_page   ((g == 0) ? page_number : cell_page[(g == 0) ? 0 : g - 1]),
        .lookup_page (page_number),
        .count       (resident_count),
        .page        (cell_page[g]),
        .victim      (cell_victim[g]),
        .stat        (cell_stat[g])
      );
    end
  endgenerate

  // Combine cell reports: any match, and the one oldest page
  always_comb begin
    found  = 1'b0;
    victim = '0;
    for (int i = 0; i < FRAMES; i++) begin
      found  = found | cell_stat[i].match;
      victim = victim | cell_victim[i];
    end
  end

  // A fault with every usable frame taken drops the oldest page; the count
  // then holds, since the new page takes its place at the young end.
  assign evict = !found && (CAP_W'(resident_count) >= capacity);
  assign shift = accept && !found;

  always_comb begin
    resident_count_next = resident_count;
    hits_total_next     = hits_total;
    faults_total_next   = faults_total;
    if (accept) begin
      if (found) begin
        if (hits_total != TOTAL_MAX) begin
          hits_total_next = hits_total + TOTAL_W'(1);
        end
      end else begin
        if (faults_total != TOTAL_MAX) begin
          faults_total_next = faults_total + TOTAL_W'(1);
        end
        if (!evict) begin
          resident_count_next = resident_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use  <= CFG_W'(16);
      resident_count <= '0;
      hits_total     <= '0;
      faults_total   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_data;
      end
      resident_count <= resident_count_next;
      hits_total     <= hits_total_next;
      faults_total   <= faults_total_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      hit           <= found;
      evicted_valid <= evict;
      evicted_page  <= evict ? victim : '0;
      hit_count     <= hits_total_next;
      fault_count   <= faults_total_next;
    end
  end

  // Assertions

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CAP_W'(resident_count) <= CAP_MAX)
    else $error("resident count above frame total");

  a_evict_holds_count: assert property (@(posedge clk) disable iff (rst)
    accept && evict |=> resident_count == $past(resident_count))
    else $error("eviction changed resident count");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("hit reported together with eviction");

  a_evict_needs_page: assert property (@(posedge clk) disable iff (rst)
    accept && evict |-> resident_count != '0)
    else $error("eviction from an empty store");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import fpr_pkg::*;

  localparam int PW          = PAGE_BITS_DEF;
  localparam int NFRAMES     = FRAMES_DEF;
  localparam int QUIET_LIMIT = 4000;   // cycles with no handshake on either side
  localparam int PHASE_LEN   = 55;     // requests per random phase

  // Idling modes: sender gaps and receiver stalls, in percent
  typedef enum int { IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE } idle_mode_t;

  typedef struct {
    logic               hit;
    logic               ev_valid;
    logic [PW-1:0]      ev_page;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] faults;
  } page_result_t;

  // Predicts the FIFO replacement and holds the results still owed by the block.
  class page_fifo_tracker;
    logic [PW-1:0]      frame_page [NFRAMES];
    int unsigned        oldest;
    int unsigned        resident;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] faults;
    logic [CFG_W-1:0]   frames_cfg;
    page_result_t       awaited_results [$];
    int                 failures;

    function new();
      oldest     = 0;
      resident   = 0;
      hits       = '0;
      faults     = '0;
      frames_cfg = CFG_W'(NFRAMES);
      failures   = 0;
    endfunction

    function void set_frames(logic [CFG_W-1:0] v);
      frames_cfg = v;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // Accepted request: work out the result and queue it
    function void note_request(logic [PW-1:0] page);
      page_result_t r;
      int unsigned  cap;
      r.hit      = 1'b0;
      r.ev_valid = 1'b0;
      r.ev_page  = '0;
      cap = frames_cfg;
      if (cap == 0) cap = 1;
      if (cap > NFRAMES) cap = NFRAMES;
      // only resident entries take part in the compare
      for (int i = 0; i < resident; i++) begin
        if (frame_page[(oldest + i) % NFRAMES] == page) r.hit = 1'b1;
      end
      if (r.hit) begin
        if (hits != '1) hits = hits + 1;
      end else begin
        if (faults != '1) faults = faults + 1;
        // full (or over-full after a lowered frame count): drop one oldest page
        if (resident >= cap) begin
          r.ev_valid = 1'b1;
          r.ev_page  = frame_page[oldest];
          oldest     = (oldest + 1) % NFRAMES;
          resident--;
        end
        frame_page[(oldest + resident) % NFRAMES] = page;
        resident++;
      end
      r.hits   = hits;
      r.faults = faults;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic hit, logic ev_valid, logic [PW-1:0] ev_page,
                               logic [TOTAL_W-1:0] hit_cnt, logic [TOTAL_W-1:0] fault_cnt);
      page_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("hit", TOTAL_W'(want.hit), TOTAL_W'(hit));
      compare_field("evicted_valid", TOTAL_W'(want.ev_valid), TOTAL_W'(ev_valid));
      compare_field("evicted_page", TOTAL_W'(want.ev_page), TOTAL_W'(ev_page));
      compare_field("hit_count", want.hits, hit_cnt);
      compare_field("fault_count", want.faults, fault_cnt);
    endfunction
  endclass

  // All inputs start at known values
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PW-1:0]      page_number = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               hit;
  logic               evicted_valid;
  logic [PW-1:0]      evicted_page;
  logic [TOTAL_W-1:0] hit_count;
  logic [TOTAL_W-1:0] fault_count;

  page_fifo_tracker tracker;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               quiet_cycles   = 0;

  fifo_page_replacement dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .page_number  (page_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page),
    .hit_count    (hit_count),
    .fault_count  (fault_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls at the rate of the current idling mode
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor: every drained result is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_result(hit, evicted_valid, evicted_page, hit_count, fault_count);
  end

  // Watchdog: too long without any handshake means the block has hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic set_idle(idle_mode_t m);
    case (m)
      IDLE_SEND_LIGHT: begin
        send_idle_pct  = 9;
        recv_stall_pct = 87;
      end
      IDLE_SEND_HEAVY: begin
        send_idle_pct  = 87;
        recv_stall_pct = 9;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // One request: optional gap, then hold it until the block takes it.
  // in_valid stays high on return; the caller lowers it when a batch ends.
  task automatic send_page(logic [PW-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    page_number <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Frame count is only changed with the block idle
  task automatic write_frames(logic [CFG_W-1:0] v);
    drain();
    repeat (3) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_frames(v);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_frames [9];
    logic [PW-1:0]    pool_base;
    int unsigned      spread;
    idle_mode_t       mode;

    tracker = new();
    phase_frames = '{5'd1, 5'd2, 5'd17, 5'd5, 5'd16, 5'd31, 5'd0, 5'd8, 5'd3};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset frame count of 16
    set_idle(IDLE_SEND_LIGHT);
    send_page(16'h0000);                   // empty store: cold fault, no eviction
    send_page(16'hFFFF);
    send_page(16'h0000);                   // hits on both extremes
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
    for (int i = 1; i <= 12; i++) send_page(PW'(i));   // store now full
    send_page(16'h1234);                   // full: oldest (0x0000) goes
    send_page(16'h0000);                   // back again, 0xFFFF goes
    send_page(16'h5555);                   // still resident
    // lowered below residency: zero acts as one, each fault drops only one page
    write_frames(5'd0);
    send_page(16'h8001);
    send_page(16'h8002);
    send_page(16'h0004);                   // still resident from the full store
    send_page(16'h8003);
    // above the frame count: acts as the full sixteen
    write_frames(5'd31);
    send_page(16'h8003);
    send_page(16'h7FFE);

    // Random part: small pools give hits and evictions, wide values the rest
    for (int ph = 0; ph < 9; ph++) begin
      mode = (ph < 3) ? IDLE_SEND_LIGHT : (ph < 6) ? IDLE_SEND_HEAVY : IDLE_NONE;
      write_frames(phase_frames[ph]);
      set_idle(mode);
      pool_base = PW'($urandom_range(65535 - 24));
      spread    = (phase_frames[ph] == 0) ? 3 :
                  (phase_frames[ph] > NFRAMES) ? NFRAMES + 3 : phase_frames[ph] + 3;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(99) < 75)
          send_page(pool_base + PW'($urandom_range(spread)));
        else
          send_page(PW'($urandom_range(65535)));
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
